FILE: hw/rtl/sto_pkg.sv
// shared types and constants for the sorted timeout queue
`timescale 1ns / 1ps
package sto_pkg;

    localparam int SLOT_MAXW = 6;
    localparam int MAX_RES   = 32;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_ARM       = 3'd1;
    localparam logic [2:0] OP_CANCEL    = 3'd2;
    localparam logic [2:0] OP_ALLOC     = 3'd3;
    localparam logic [2:0] OP_CANCEL_TAG = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef enum logic [1:0] {
        AFTER_INSERT = 2'd0,
        AFTER_TICK   = 2'd1,
        AFTER_DONE   = 2'd2
    } after_rm_t;

    typedef struct packed {
        logic [SLOT_MAXW-1:0] ord_ra;
        logic                 ord_we;
        logic [SLOT_MAXW-1:0] ord_wa;
        logic [SLOT_MAXW-1:0] ord_wd;
        logic                 slot_we;
        logic [SLOT_MAXW-1:0] slot_wa;
        logic [31:0]          slot_wdl;
        logic [31:0]          slot_wtag;
        logic                 rd_direct;
        logic [SLOT_MAXW-1:0] rd_slot;
        logic                 q_set;
        logic                 q_clr;
        logic [SLOT_MAXW-1:0] q_idx;
    } sto_ctl_t;

endpackage

FILE: hw/rtl/sto_store.sv
// slot storage: order list, deadlines, tags and queued flags
`timescale 1ns / 1ps
module sto_store
    import sto_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sto_ctl_t                   ctl,
    output logic [$clog2(SLOTS)-1:0]   ord_rd,
    output logic [31:0]                dl_rd,
    output logic [31:0]                tag_rd,
    output logic [SLOTS-1:0]           queued
);
    localparam int IW = $clog2(SLOTS);

    logic [IW-1:0] order_mem [SLOTS];
    logic [31:0]   dl_mem    [SLOTS];
    logic [31:0]   tag_mem   [SLOTS];
    logic [SLOTS-1:0] queued_reg;
    logic [SLOTS-1:0] queued_next;
    logic [IW-1:0] sidx;

    always_ff @(posedge aclk) begin
        if (ctl.ord_we) begin
            order_mem[IW'(ctl.ord_wa)] <= IW'(ctl.ord_wd);
        end
        if (ctl.slot_we) begin
            dl_mem[IW'(ctl.slot_wa)]  <= ctl.slot_wdl;
            tag_mem[IW'(ctl.slot_wa)] <= ctl.slot_wtag;
        end
    end

    always_comb begin
        queued_next = queued_reg;
        if (ctl.q_clr) queued_next[IW'(ctl.q_idx)] = 1'b0;
        if (ctl.q_set) queued_next[IW'(ctl.q_idx)] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg <= '0;
        end else begin
            queued_reg <= queued_next;
        end
    end

    assign ord_rd = order_mem[IW'(ctl.ord_ra)];
    assign sidx   = ctl.rd_direct ? IW'(ctl.rd_slot) : ord_rd;
    assign dl_rd  = dl_mem[sidx];
    assign tag_rd = tag_mem[sidx];
    assign queued = queued_reg;

endmodule

FILE: hw/rtl/sorted_timeout_queue.sv
// sorted timeout queue: sequencer walking the order list with one shared compare
// arm scans for the insert point and shifts the tail up, first finding and unlinking a re-armed
// slot; cancel finds and unlinks; alloc first scans for a free slot; one walk step a cycle
// tick: fires due items from the head, each unlinked and then passed to the output,
// one item at a time, s_ready only while idle
// reset: synchronous active low, clears count, length and queued flags
`timescale 1ns / 1ps
module sorted_timeout_queue
    import sto_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [4:0]  s_slot,
    input  logic [31:0] s_interval,
    input  logic [31:0] s_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_slot_out,
    output logic [31:0] m_tag_out,
    output logic        m_fired,
    output logic        m_last
);
    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_TCHK  = 10'b0000000010,
        S_FIND  = 10'b0000000100,
        S_SHDN  = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_SHUP  = 10'b0000100000,
        S_PUT   = 10'b0001000000,
        S_ALLOC = 10'b0010000000,
        S_TAGS  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] count_reg, count_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [5:0] n_reg, n_next;
    logic pend_reg, pend_next;
    after_rm_t after_reg, after_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [31:0] dl_reg, dl_next;
    logic [31:0] tag_reg, tag_next;
    logic        valid_reg, valid_next;
    logic [1:0]  status_reg, status_next;
    logic [4:0]  sout_reg, sout_next;
    logic [31:0] tout_reg, tout_next;
    logic        fired_reg, fired_next;
    logic        last_reg, last_next;

    sto_ctl_t ctl;
    logic [IW-1:0] ord_rd;
    logic [31:0] dl_rd, tag_rd;
    logic [SLOTS-1:0] queued;

    logic [31:0] cmp_b;
    logic        dl_le;
    logic        slot_ok;
    logic [IW-1:0] in_idx;
    logic [LW-1:0] idx_inc;

    sto_store #(.SLOTS(SLOTS)) u_store (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
        .ord_rd(ord_rd), .dl_rd(dl_rd), .tag_rd(tag_rd), .queued(queued)
    );

    // shared deadline compare
    assign cmp_b   = (state_reg == S_TCHK) ? count_reg : dl_reg;
    assign dl_le   = dl_rd <= cmp_b;
    assign slot_ok = 32'(s_slot) < SLOTS;
    assign in_idx  = IW'(s_slot);
    assign idx_inc = idx_reg + LW'(1);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        pend_next   = pend_reg;
        after_next  = after_reg;
        slot_next   = slot_reg;
        dl_next     = dl_reg;
        tag_next    = tag_reg;
        valid_next  = valid_reg;
        status_next = status_reg;
        sout_next   = sout_reg;
        tout_next   = tout_reg;
        fired_next  = fired_reg;
        last_next   = last_reg;
        ctl           = '0;
        ctl.ord_ra    = SLOT_MAXW'(idx_reg[IW-1:0]);
        ctl.slot_wa   = SLOT_MAXW'(slot_reg);
        ctl.slot_wdl  = dl_reg;
        ctl.slot_wtag = tag_reg;
        ctl.q_idx     = SLOT_MAXW'(slot_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    slot_next   = in_idx;
                    dl_next     = count_reg + s_interval;
                    tag_next    = s_tag;
                    idx_next    = '0;
                    pos_next    = '0;
                    status_next = ST_MISS;
                    sout_next   = s_slot;
                    tout_next   = '0;
                    fired_next  = 1'b0;
                    last_next   = 1'b1;
                    ctl.rd_direct = 1'b1;
                    ctl.rd_slot   = SLOT_MAXW'(in_idx);
                    unique case (s_operation)
                        OP_TICK: begin
                            count_next = count_reg + 32'd1;
                            n_next     = '0;
                            pend_next  = 1'b0;
                            state_next = S_TCHK;
                        end
                        OP_ARM: begin
                            if (!slot_ok) begin
                                valid_next = 1'b1;
                                state_next = S_OUT;
                            end else if (queued[in_idx]) begin
                                after_next = AFTER_INSERT;
                                state_next = S_FIND;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_CANCEL: begin
                            if (slot_ok && queued[in_idx]) begin
                                status_next = ST_OK;
                                tout_next   = tag_rd;
                                after_next  = AFTER_DONE;
                                state_next  = S_FIND;
                            end else begin
                                valid_next = 1'b1;
                                state_next = S_OUT;
                            end
                        end
                        OP_ALLOC:      state_next = S_ALLOC;
                        OP_CANCEL_TAG: state_next = S_TAGS;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_TCHK: begin
                ctl.ord_ra = '0;
                if (len_reg != '0 && n_reg < 6'(MAX_RES) && dl_le) begin
                    if (pend_reg) begin
                        valid_next = 1'b1;
                        last_next  = 1'b0;
                        state_next = S_OUT;
                    end else begin
                        status_next = ST_OK;
                        sout_next   = 5'(ord_rd);
                        tout_next   = tag_rd;
                        fired_next  = 1'b1;
                        pend_next   = 1'b1;
                        n_next      = n_reg + 6'd1;
                        ctl.q_clr   = 1'b1;
                        ctl.q_idx   = SLOT_MAXW'(ord_rd);
                        idx_next    = '0;
                        after_next  = AFTER_TICK;
                        state_next  = S_SHDN;
                    end
                end else if (pend_reg) begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FIND: begin
                if (ord_rd == slot_reg) begin
                    ctl.q_clr  = 1'b1;
                    state_next = S_SHDN;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_SHDN: begin
                ctl.ord_ra = SLOT_MAXW'(idx_inc[IW-1:0]);
                if (idx_inc < len_reg) begin
                    ctl.ord_we = 1'b1;
                    ctl.ord_wa = SLOT_MAXW'(idx_reg[IW-1:0]);
                    ctl.ord_wd = SLOT_MAXW'(ord_rd);
                    idx_next   = idx_inc;
                end else begin
                    len_next = len_reg - LW'(1);
                    idx_next = '0;
                    unique case (after_reg)
                        AFTER_INSERT: state_next = S_SCAN;
                        AFTER_TICK:   state_next = S_TCHK;
                        default: begin
                            valid_next = 1'b1;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (idx_reg < len_reg && dl_le) begin
                    idx_next = idx_inc;
                end else begin
                    pos_next   = idx_reg;
                    idx_next   = len_reg;
                    state_next = S_SHUP;
                end
            end
            S_SHUP: begin
                ctl.ord_ra = SLOT_MAXW'(idx_reg[IW-1:0] - IW'(1));
                if (idx_reg > pos_reg) begin
                    ctl.ord_we = 1'b1;
                    ctl.ord_wa = SLOT_MAXW'(idx_reg[IW-1:0]);
                    ctl.ord_wd = SLOT_MAXW'(ord_rd);
                    idx_next   = idx_reg - LW'(1);
                end else begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                ctl.ord_we  = 1'b1;
                ctl.ord_wa  = SLOT_MAXW'(pos_reg[IW-1:0]);
                ctl.ord_wd  = SLOT_MAXW'(slot_reg);
                ctl.slot_we = 1'b1;
                ctl.q_set   = 1'b1;
                len_next    = len_reg + LW'(1);
                status_next = ST_OK;
                sout_next   = 5'(slot_reg);
                tout_next   = tag_reg;
                valid_next  = 1'b1;
                state_next  = S_OUT;
            end
            S_ALLOC: begin
                if (idx_reg == LW'(SLOTS)) begin
                    status_next = ST_FULL;
                    sout_next   = '0;
                    valid_next  = 1'b1;
                    state_next  = S_OUT;
                end else if (!queued[idx_reg[IW-1:0]]) begin
                    slot_next  = idx_reg[IW-1:0];
                    idx_next   = '0;
                    state_next = S_SCAN;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_TAGS: begin
                if (idx_reg < len_reg) begin
                    if (tag_rd == tag_reg) begin
                        status_next = ST_OK;
                        sout_next   = 5'(ord_rd);
                        tout_next   = tag_reg;
                        ctl.q_clr   = 1'b1;
                        ctl.q_idx   = SLOT_MAXW'(ord_rd);
                        after_next  = AFTER_DONE;
                        state_next  = S_SHDN;
                    end else begin
                        idx_next = idx_inc;
                    end
                end else begin
                    sout_next  = '0;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    valid_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = last_reg ? S_IDLE : S_TCHK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            n_reg     <= '0;
            after_reg <= AFTER_DONE;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            n_reg     <= n_next;
            after_reg <= after_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        slot_reg   <= slot_next;
        dl_reg     <= dl_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        sout_reg   <= sout_next;
        tout_reg   <= tout_next;
        fired_reg  <= fired_next;
        last_reg   <= last_next;
    end

    assign s_ready    = state_reg == S_IDLE;
    assign m_valid    = valid_reg;
    assign m_status   = status_reg;
    assign m_slot_out = sout_reg;
    assign m_tag_out  = tout_reg;
    assign m_fired    = fired_reg;
    assign m_last     = last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(len_reg) <= SLOTS) else $error("queue length overflow");
    a_len_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ($countones(queued) == 32'(len_reg)))
        else $error("queued flags disagree with length");
    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fired) |-> (m_status == ST_OK)) else $error("fired item not ok");

endmodule

FILE: dv/tb_sorted_timeout_queue.sv
// testbench for the sorted timeout queue: directed corners and random traffic checked against a scoreboard
`timescale 1ns / 1ps
module tb_sorted_timeout_queue;
    import sto_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [31:0] tag;
        logic        fired;
        logic        last;
    } timer_event_t;

    class timeout_scoreboard;
        logic [31:0]  tick_count;
        logic [31:0]  deadline [32];
        logic [31:0]  slot_tag [32];
        bit           queued [32];
        logic [4:0]   order [$];
        timer_event_t pending [$];
        int           mismatches;

        function void clear();
            tick_count = 0;
            order.delete();
            pending.delete();
            mismatches = 0;
            foreach (queued[i]) queued[i] = 0;
        endfunction

        function void push(logic [1:0] st, logic [4:0] s, logic [31:0] t, logic f);
            timer_event_t e;
            e.status = st;
            e.slot = s;
            e.tag = t;
            e.fired = f;
            e.last = 1'b1;
            pending.push_back(e);
        endfunction

        function void unlink(logic [4:0] s);
            foreach (order[i]) begin
                if (order[i] == s) begin
                    order.delete(i);
                    break;
                end
            end
            queued[s] = 0;
        endfunction

        function void link(logic [4:0] s, logic [31:0] dl, logic [31:0] t);
            int pos;
            pos = 0;
            if (queued[s]) unlink(s);
            while (pos < order.size() && deadline[order[pos]] <= dl) pos++;
            order.insert(pos, s);
            deadline[s] = dl;
            slot_tag[s] = t;
            queued[s] = 1;
        endfunction

        function void note_input(logic [2:0] op, logic [4:0] s, logic [31:0] iv,
                                 logic [31:0] t);
            int n;
            bit hit;
            logic [4:0] h;
            n = 0;
            hit = 0;
            case (op)
                OP_TICK: begin
                    tick_count = tick_count + 1;
                    while (order.size() > 0 && n < MAX_RES) begin
                        h = order[0];
                        if (deadline[h] > tick_count) break;
                        push(ST_OK, h, slot_tag[h], 1'b1);
                        pending[$].last = 1'b0;
                        unlink(h);
                        n++;
                    end
                    if (n > 0) pending[$].last = 1'b1;
                end
                OP_ARM: begin
                    link(s, tick_count + iv, t);
                    push(ST_OK, s, t, 1'b0);
                end
                OP_CANCEL: begin
                    if (queued[s]) begin
                        push(ST_OK, s, slot_tag[s], 1'b0);
                        unlink(s);
                    end else begin
                        push(ST_MISS, s, 32'd0, 1'b0);
                    end
                end
                OP_ALLOC: begin
                    for (int i = 0; i < 32; i++) begin
                        if (!queued[i]) begin
                            link(i[4:0], tick_count + iv, t);
                            push(ST_OK, i[4:0], t, 1'b0);
                            hit = 1;
                            break;
                        end
                    end
                    if (!hit) push(ST_FULL, 5'd0, 32'd0, 1'b0);
                end
                OP_CANCEL_TAG: begin
                    foreach (order[i]) begin
                        h = order[i];
                        if (slot_tag[h] == t) begin
                            push(ST_OK, h, t, 1'b0);
                            unlink(h);
                            hit = 1;
                            break;
                        end
                    end
                    if (!hit) push(ST_MISS, 5'd0, 32'd0, 1'b0);
                end
                default: ;
            endcase
        endfunction

        function void check_result(timer_event_t got);
            timer_event_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d slot %0d tag %h", got.status,
                             got.slot, got.tag);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.slot !== want.slot
                    || got.tag !== want.tag || got.fired !== want.fired
                    || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"exp st %0d slot %0d tag %h fired %0d last %0d, ",
                              "got st %0d slot %0d tag %h fired %0d last %0d"},
                             want.status, want.slot, want.tag, want.fired, want.last,
                             got.status, got.slot, got.tag, got.fired, got.last);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [4:0]  s_slot;
    logic [31:0] s_interval;
    logic [31:0] s_tag;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [4:0]  m_slot_out;
    logic [31:0] m_tag_out;
    logic        m_fired;
    logic        m_last;

    timeout_scoreboard sb;
    bit          no_gaps;
    int          quiet_cycles = 0;
    logic [31:0] recent_tags [8];

    localparam int WATCHDOG = 4000;

    sorted_timeout_queue #(.SLOTS(32)) DUT (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send(logic [2:0] op, logic [4:0] s, logic [31:0] iv, logic [31:0] t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_slot <= s;
        s_interval <= iv;
        s_tag <= t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 6);
        if (r < 9) return $urandom_range(0, 40);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_tag();
        logic [31:0] t;
        t = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom;
        recent_tags[$urandom_range(0, 7)] = t;
        return t;
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) send(OP_TICK, 5'($urandom), $urandom, $urandom);
        else if (r < 55) send(OP_ARM, 5'($urandom), pick_interval(), pick_tag());
        else if (r < 70) send(OP_CANCEL, 5'($urandom), $urandom, $urandom);
        else if (r < 85) send(OP_ALLOC, 5'($urandom), pick_interval(), pick_tag());
        else if (r < 96)
            send(OP_CANCEL_TAG, 5'($urandom), $urandom,
                 ($urandom_range(0, 3) == 0) ? $urandom : recent_tags[$urandom_range(0, 7)]);
        else send(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 5'($urandom), $urandom,
                  $urandom);
    endtask

    // result side stalls
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        timer_event_t got;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (s_valid && s_ready) begin
                sb.note_input(s_operation, s_slot, s_interval, s_tag);
            end
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.slot = m_slot_out;
                got.tag = m_tag_out;
                got.fired = m_fired;
                got.last = m_last;
                sb.check_result(got);
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("sorted_timeout_queue: mismatch");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        sb.clear();
        no_gaps = 0;
        foreach (recent_tags[i]) recent_tags[i] = i;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_TICK;
        s_slot = '0;
        s_interval = '0;
        s_tag = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed corners
        send(OP_TICK, 5'd0, 32'd0, 32'd0);
        send(OP_CANCEL, 5'd31, 32'd0, 32'd0);
        send(OP_CANCEL_TAG, 5'd0, 32'd0, 32'hFFFF_FFFF);
        send(OP_ARM, 5'd0, 32'd0, 32'hFFFF_FFFF);
        send(OP_ARM, 5'd31, 32'hFFFF_FFFF, 32'h0000_0000);
        send(OP_ARM, 5'd5, 32'd1, 32'hA5A5_5A5A);
        send(OP_ARM, 5'd6, 32'd1, 32'h5A5A_A5A5);
        send(OP_ARM, 5'd5, 32'd3, 32'h1234_5678);
        send(OP_TICK, 5'd0, 32'd0, 32'd0);
        send(OP_ARM, 5'd7, 32'hFFFF_FFFF, 32'd9);
        send(OP_TICK, 5'd0, 32'd0, 32'd0);
        send(OP_CANCEL, 5'd5, 32'd0, 32'd0);
        send(OP_CANCEL_TAG, 5'd0, 32'd0, 32'd0);
        send(OP_UNUSED_LO, 5'd1, 32'd1, 32'd1);
        send(OP_UNUSED_HI, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // fill every slot, overflow, then fire them all on one tick
        repeat (33) send(OP_ALLOC, 5'd0, 32'd1, $urandom);
        send(OP_TICK, 5'd0, 32'd0, 32'd0);
        send(OP_TICK, 5'd0, 32'd0, 32'd0);

        for (int n = 0; n < 300; n++) begin
            if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            random_item();
        end
        no_gaps = 0;
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("sorted_timeout_queue: match");
        else
            $display("sorted_timeout_queue: mismatch");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/sto_pkg.sv
hw/rtl/sto_store.sv
hw/rtl/sorted_timeout_queue.sv
dv/tb_sorted_timeout_queue.sv
